### hw/rtl/bthin_pkg.sv
`timescale 1ns / 1ps

package bthin_pkg;

  // Fixed field widths of the two channels and of the size registers.
  localparam int ROW_BITS_W = 64;
  localparam int ROW_IDX_W  = 6;
  localparam int FUNC_W     = 2;
  localparam int PASS_W     = 8;
  localparam int CFG_W      = 7;

  // Default store geometry.
  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 64;

  // Register reset values.
  localparam int WIDTH_RESET  = 64;
  localparam int HEIGHT_RESET = 64;

  // Neighborhood limits of the thinning rule.
  localparam int NB_COUNT = 8;
  localparam int NB_MIN   = 2;
  localparam int NB_MAX   = 6;

  // Command codes.
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_THIN  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  // Register select, taken from the word address.
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  typedef struct packed {
    logic [FUNC_W-1:0]     func;
    logic [ROW_IDX_W-1:0]  row_index;
    logic [ROW_BITS_W-1:0] row_bits;
  } in_item_t;

  typedef struct packed {
    logic [ROW_BITS_W-1:0] read_bits;
    logic [PASS_W-1:0]     pass_count;
  } out_item_t;

  // Ring is clockwise from north: bit 0 north, bit 7 north-west.
  typedef struct packed {
    logic [NB_COUNT-1:0] ring;
    logic                center;
  } nbhd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PASS,
    ST_SUB_INIT,
    ST_SUB_LOAD,
    ST_SUB_ROW,
    ST_DONE
  } state_e;

endpackage

### hw/rtl/bthin_lane.sv
`timescale 1ns / 1ps

module bthin_lane (
  input  bthin_pkg::nbhd_t nb_i,
  input  logic             phase_i,
  output logic             kill_o
);

  localparam int CntW = $clog2(bthin_pkg::NB_COUNT + 1);

  logic [bthin_pkg::NB_COUNT-1:0] p;
  logic [bthin_pkg::NB_COUNT-1:0] p_next;
  logic [CntW-1:0]                b;
  logic [CntW-1:0]                a;
  logic                           count_ok;
  logic                           phase_ok;

  assign p      = nb_i.ring;
  // p_next[k] is the clockwise successor of p[k].
  assign p_next = {p[0], p[bthin_pkg::NB_COUNT-1:1]};

  assign b = CntW'($countones(p));
  assign a = CntW'($countones(~p & p_next));

  assign count_ok = (b >= CntW'(bthin_pkg::NB_MIN)) && (b <= CntW'(bthin_pkg::NB_MAX)) &&
                    (a == CntW'(1));

  always_comb begin
    if (phase_i) begin
      phase_ok = !((p[0] & p[2] & p[6]) | (p[0] & p[4] & p[6]));
    end else begin
      phase_ok = !((p[0] & p[2] & p[4]) | (p[2] & p[4] & p[6]));
    end
  end

  assign kill_o = nb_i.center & count_ok & phase_ok;

endmodule

### hw/rtl/bthin_row.sv
`timescale 1ns / 1ps

module bthin_row #(
  parameter int Width = bthin_pkg::MAX_WIDTH_DEF
) (
  input  logic [Width-1:0] prev_i,
  input  logic [Width-1:0] cur_i,
  input  logic [Width-1:0] next_i,
  input  logic             phase_i,
  output logic [Width-1:0] row_o,
  output logic             any_o
);

  // Rows padded with a zero column on each side; column x sits at x+1.
  logic [Width+1:0] prev_p;
  logic [Width+1:0] cur_p;
  logic [Width+1:0] next_p;
  logic [Width-1:0] kill;

  assign prev_p = {1'b0, prev_i, 1'b0};
  assign cur_p  = {1'b0, cur_i, 1'b0};
  assign next_p = {1'b0, next_i, 1'b0};

  for (genvar x = 0; x < Width; x++) begin : g_lane
    bthin_pkg::nbhd_t nb;

    assign nb = '{ring:   {prev_p[x], cur_p[x], next_p[x], next_p[x+1],
                           next_p[x+2], cur_p[x+2], prev_p[x+2], prev_p[x+1]},
                  center: cur_i[x]};

    bthin_lane u_lane (
      .nb_i    (nb),
      .phase_i (phase_i),
      .kill_o  (kill[x])
    );
  end

  // Merge: clear every pixel a lane marked and flag whether anything went.
  assign row_o = cur_i & ~kill;
  assign any_o = |kill;

endmodule

### hw/rtl/binary_image_thinning.sv
`timescale 1ns / 1ps

// Binary image skeletonizer with a row store of one bit per pixel.
// The input channel carries commands: write a row, run thinning, read a row.
// Every command returns exactly one result on the output channel, with the
// stored row for a read (zero otherwise) and the pass count of the last thin.
// Row writes and reads are taken one per cycle while the output does not
// stall; a result goes through the read-data stage to the output register.
// A thin command holds off further commands while it runs. The image is
// swept one row per cycle, all columns at once in parallel lanes. A pass is
// ST_PASS, then two sub-iterations of ST_SUB_INIT, ST_SUB_LOAD and one
// ST_SUB_ROW per row of the effective height, min(image_height, MAX_HEIGHT).
// An empty image skips the sub-iterations. Image size registers are written
// over the APB-style port; the user must write them only while idle, and the
// block itself does not enforce it. After reset the store is cleared one row
// per cycle, all MAX_HEIGHT rows, and in_stall_o stays high meanwhile;
// register writes are taken throughout. When the receiver stalls, the result
// waits in the output register, one more command may be taken into the read-data stage, and then in_stall_o rises.
module binary_image_thinning #(
  parameter int MAX_WIDTH  = bthin_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bthin_pkg::MAX_HEIGHT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  bthin_pkg::in_item_t  in_data_i,

  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output bthin_pkg::out_item_t out_data_o,

  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int AW     = $clog2(MAX_HEIGHT);
  localparam int CW     = $clog2(MAX_HEIGHT + 1);
  localparam int CfgW   = bthin_pkg::CFG_W;
  localparam int PassW  = bthin_pkg::PASS_W;
  localparam int RowW   = bthin_pkg::ROW_BITS_W;

  localparam logic [AW-1:0] ClrLast = AW'(MAX_HEIGHT - 1);

  // Configuration registers.
  logic [CfgW-1:0] image_width_q;
  logic [CfgW-1:0] image_height_q;

  // Control state.
  bthin_pkg::state_e state_q, state_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic [CW-1:0]     y_q, y_d;
  logic              phase_q, phase_d;
  logic              changed_q, changed_d;
  logic [PassW-1:0]  pass_q, pass_d;
  logic [PassW-1:0]  last_pass_q, last_pass_d;

  // Row window of the sweep.
  logic [MAX_WIDTH-1:0] prev_q, prev_d;
  logic [MAX_WIDTH-1:0] cur_q, cur_d;

  // Read-data stage and output register.
  logic                 s1_valid_q, s1_valid_d;
  logic                 s1_read_q, s1_read_d;
  logic                 s1_thin_q, s1_thin_d;
  logic                 out_valid_q, out_valid_d;
  bthin_pkg::out_item_t out_data_q, out_data_d;

  // Row store.
  logic [MAX_WIDTH-1:0] image_store [MAX_HEIGHT];
  logic [MAX_WIDTH-1:0] rdata_q;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [MAX_WIDTH-1:0] mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;

  logic [CfgW-1:0]      eff_w;
  logic [CW-1:0]        eff_h;
  logic [MAX_WIDTH-1:0] width_mask;
  logic                 in_ready;
  logic                 in_accept;
  logic                 s1_move;
  logic                 row_ok;
  logic [AW-1:0]        in_addr;
  logic [MAX_WIDTH-1:0] in_wdata;
  logic                 cfg_write;

  logic [CW-1:0]        y_next;
  logic [CW:0]          y_plus2;
  logic                 last_row;
  logic [MAX_WIDTH-1:0] next_row;
  logic [MAX_WIDTH-1:0] row_new;
  logic                 row_any;

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= CfgW'(bthin_pkg::WIDTH_RESET);
      image_height_q <= CfgW'(bthin_pkg::HEIGHT_RESET);
    end else if (cfg_write) begin
      unique case (paddr[2])
        bthin_pkg::REG_IMAGE_WIDTH:  image_width_q  <= pwdata[CfgW-1:0];
        bthin_pkg::REG_IMAGE_HEIGHT: image_height_q <= pwdata[CfgW-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      bthin_pkg::REG_IMAGE_WIDTH:  prdata = 32'(image_width_q);
      bthin_pkg::REG_IMAGE_HEIGHT: prdata = 32'(image_height_q);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Effective image size
  // ---------------------------------------------------------------------------
  assign eff_w = (image_width_q < CfgW'(MAX_WIDTH)) ? image_width_q : CfgW'(MAX_WIDTH);
  assign eff_h = (32'(image_height_q) < 32'(MAX_HEIGHT)) ? CW'(image_height_q)
                                                         : CW'(MAX_HEIGHT);

  always_comb begin
    for (int x = 0; x < MAX_WIDTH; x++) begin
      width_mask[x] = CfgW'(x) < eff_w;
    end
  end

  // ---------------------------------------------------------------------------
  // Command intake
  // ---------------------------------------------------------------------------
  assign s1_move   = s1_valid_q && (!s1_thin_q || (state_q == bthin_pkg::ST_IDLE)) &&
                     (!out_valid_q || !out_stall_i);
  assign in_ready  = (state_q == bthin_pkg::ST_IDLE) && (!s1_valid_q || s1_move);
  assign in_accept = in_valid_i && in_ready;
  assign in_stall_o = !in_ready;

  assign row_ok   = 32'(in_data_i.row_index) < 32'(MAX_HEIGHT);
  assign in_addr  = AW'(in_data_i.row_index);
  assign in_wdata = MAX_WIDTH'(in_data_i.row_bits) & width_mask;

  // ---------------------------------------------------------------------------
  // Sweep datapath
  // ---------------------------------------------------------------------------
  assign y_next   = y_q + 1'b1;
  assign y_plus2  = {1'b0, y_q} + (CW + 1)'(2);
  assign last_row = y_next == eff_h;
  // Rows below the image read as zero; masking also clears columns past the width.
  assign next_row = last_row ? '0 : (rdata_q & width_mask);

  bthin_row #(
    .Width (MAX_WIDTH)
  ) u_row (
    .prev_i  (prev_q),
    .cur_i   (cur_q),
    .next_i  (next_row),
    .phase_i (phase_q),
    .row_o   (row_new),
    .any_o   (row_any)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bthin_pkg::ST_CLEAR: begin
        if (clr_q == ClrLast) state_d = bthin_pkg::ST_IDLE;
      end
      bthin_pkg::ST_IDLE: begin
        if (in_accept && (in_data_i.func == bthin_pkg::FUNC_THIN)) begin
          state_d = bthin_pkg::ST_PASS;
        end
      end
      bthin_pkg::ST_PASS: begin
        state_d = (eff_h == '0) ? bthin_pkg::ST_DONE : bthin_pkg::ST_SUB_INIT;
      end
      bthin_pkg::ST_SUB_INIT: state_d = bthin_pkg::ST_SUB_LOAD;
      bthin_pkg::ST_SUB_LOAD: state_d = bthin_pkg::ST_SUB_ROW;
      bthin_pkg::ST_SUB_ROW: begin
        if (last_row) begin
          if (!phase_q) begin
            state_d = bthin_pkg::ST_SUB_INIT;
          end else if (changed_q || row_any) begin
            state_d = bthin_pkg::ST_PASS;
          end else begin
            state_d = bthin_pkg::ST_DONE;
          end
        end
      end
      bthin_pkg::ST_DONE: state_d = bthin_pkg::ST_IDLE;
      default:            state_d = bthin_pkg::ST_IDLE;
    endcase
  end

  // Store port controls.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    unique case (state_q)
      bthin_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
      end
      bthin_pkg::ST_IDLE: begin
        if (in_accept && row_ok) begin
          if (in_data_i.func == bthin_pkg::FUNC_WRITE) begin
            mem_we    = 1'b1;
            mem_waddr = in_addr;
            mem_wdata = in_wdata;
          end
          if (in_data_i.func == bthin_pkg::FUNC_READ) begin
            mem_re    = 1'b1;
            mem_raddr = in_addr;
          end
        end
      end
      bthin_pkg::ST_SUB_INIT: begin
        mem_re = 1'b1;
      end
      bthin_pkg::ST_SUB_LOAD: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(1);
      end
      bthin_pkg::ST_SUB_ROW: begin
        // Row y goes back thinned while row y+2 is fetched; the window keeps
        // the original row y for the decisions on row y+1.
        mem_we    = 1'b1;
        mem_waddr = y_q[AW-1:0];
        mem_wdata = row_new;
        mem_re    = 1'b1;
        mem_raddr = y_plus2[AW-1:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    clr_d       = clr_q;
    y_d         = y_q;
    phase_d     = phase_q;
    changed_d   = changed_q;
    pass_d      = pass_q;
    last_pass_d = last_pass_q;
    prev_d      = prev_q;
    cur_d       = cur_q;
    unique case (state_q)
      bthin_pkg::ST_CLEAR: clr_d = clr_q + 1'b1;
      bthin_pkg::ST_IDLE: begin
        if (in_accept && (in_data_i.func == bthin_pkg::FUNC_THIN)) pass_d = '0;
      end
      bthin_pkg::ST_PASS: begin
        if (pass_q != '1) pass_d = pass_q + 1'b1;
        phase_d   = 1'b0;
        changed_d = 1'b0;
      end
      bthin_pkg::ST_SUB_INIT: begin
        y_d    = '0;
        prev_d = '0;
      end
      bthin_pkg::ST_SUB_LOAD: cur_d = rdata_q & width_mask;
      bthin_pkg::ST_SUB_ROW: begin
        prev_d    = cur_q;
        cur_d     = next_row;
        y_d       = y_next;
        changed_d = changed_q | row_any;
        if (last_row) phase_d = 1'b1;
      end
      bthin_pkg::ST_DONE: last_pass_d = pass_q;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result path
  // ---------------------------------------------------------------------------
  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_read_d  = s1_read_q;
    s1_thin_d  = s1_thin_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
      s1_read_d  = (in_data_i.func == bthin_pkg::FUNC_READ) && row_ok;
      s1_thin_d  = in_data_i.func == bthin_pkg::FUNC_THIN;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end

    out_data_d = out_data_q;
    if (s1_move) begin
      out_valid_d           = 1'b1;
      out_data_d.read_bits  = s1_read_q ? RowW'(rdata_q) : '0;
      out_data_d.pass_count = last_pass_q;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bthin_pkg::ST_CLEAR;
      clr_q       <= '0;
      y_q         <= '0;
      phase_q     <= 1'b0;
      changed_q   <= 1'b0;
      pass_q      <= '0;
      last_pass_q <= '0;
      s1_valid_q  <= 1'b0;
      s1_read_q   <= 1'b0;
      s1_thin_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      y_q         <= y_d;
      phase_q     <= phase_d;
      changed_q   <= changed_d;
      pass_q      <= pass_d;
      last_pass_q <= last_pass_d;
      s1_valid_q  <= s1_valid_d;
      s1_read_q   <= s1_read_d;
      s1_thin_q   <= s1_thin_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q     <= prev_d;
    cur_q      <= cur_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      image_store[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= image_store[mem_raddr];
    end
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam logic [bthin_pkg::FUNC_W-1:0] FUNC_NONE = 2'd3;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 1250;
  localparam int MAX_ROWS     = bthin_pkg::MAX_HEIGHT_DEF;
  localparam int MAX_COLS     = bthin_pkg::MAX_WIDTH_DEF;

  // Keeps its own copy of the pixel store and the size registers, and
  // predicts the reply for every command that has been transferred.
  class thinning_scoreboard;
    logic [bthin_pkg::ROW_BITS_W-1:0] store [MAX_ROWS];
    logic [bthin_pkg::PASS_W-1:0]     last_passes;
    int unsigned                      width_reg;
    int unsigned                      height_reg;
    bthin_pkg::out_item_t             replies_due[$];
    int                               fails;

    function new();
      foreach (store[i]) store[i] = '0;
      last_passes = '0;
      width_reg   = bthin_pkg::WIDTH_RESET;
      height_reg  = bthin_pkg::HEIGHT_RESET;
      fails       = 0;
    endfunction

    function void set_size(logic sel, int unsigned v);
      if (sel == bthin_pkg::REG_IMAGE_WIDTH) width_reg = v & 'h7F;
      else height_reg = v & 'h7F;
    endfunction

    function int cols_in_use();
      return (width_reg < MAX_COLS) ? width_reg : MAX_COLS;
    endfunction

    function int rows_in_use();
      return (height_reg < MAX_ROWS) ? height_reg : MAX_ROWS;
    endfunction

    function logic [bthin_pkg::ROW_BITS_W-1:0] col_mask();
      int w;
      w = cols_in_use();
      if (w >= bthin_pkg::ROW_BITS_W) return '1;
      return (64'd1 << w) - 64'd1;
    endfunction

    function bit px(int x, int y, int w, int h);
      if (x < 0 || y < 0 || x >= w || y >= h) return 1'b0;
      return store[y][x];
    endfunction

    // One sub-iteration. All deletions are collected first and applied at
    // the end, so decisions only see the image as it was at the start.
    function bit thin_sweep(int w, int h, bit second);
      logic [bthin_pkg::ROW_BITS_W-1:0] kill [MAX_ROWS];
      logic [bthin_pkg::NB_COUNT-1:0]   ring;
      int                               cnt;
      int                               trans;
      bit                               any;
      any = 1'b0;
      for (int y = 0; y < h; y++) begin
        kill[y] = '0;
        for (int x = 0; x < w; x++) begin
          if (!px(x, y, w, h)) continue;
          // Clockwise from north.
          ring[0] = px(x, y - 1, w, h);
          ring[1] = px(x + 1, y - 1, w, h);
          ring[2] = px(x + 1, y, w, h);
          ring[3] = px(x + 1, y + 1, w, h);
          ring[4] = px(x, y + 1, w, h);
          ring[5] = px(x - 1, y + 1, w, h);
          ring[6] = px(x - 1, y, w, h);
          ring[7] = px(x - 1, y - 1, w, h);
          cnt   = 0;
          trans = 0;
          for (int k = 0; k < bthin_pkg::NB_COUNT; k++) begin
            cnt += ring[k];
            if (!ring[k] && ring[(k + 1) % bthin_pkg::NB_COUNT]) trans++;
          end
          if (cnt < bthin_pkg::NB_MIN || cnt > bthin_pkg::NB_MAX || trans != 1) continue;
          if (!second) begin
            if ((ring[0] & ring[2] & ring[4]) | (ring[2] & ring[4] & ring[6])) continue;
          end else begin
            if ((ring[0] & ring[2] & ring[6]) | (ring[0] & ring[4] & ring[6])) continue;
          end
          kill[y][x] = 1'b1;
          any = 1'b1;
        end
      end
      for (int y = 0; y < h; y++) store[y] &= ~kill[y];
      return any;
    endfunction

    function void thin_store();
      int w;
      int h;
      int passes;
      bit changed;
      w = cols_in_use();
      h = rows_in_use();
      for (int y = 0; y < h; y++) store[y] &= col_mask();
      passes  = 0;
      changed = 1'b1;
      while (changed) begin
        changed = 1'b0;
        if (passes < 255) passes++;
        if (thin_sweep(w, h, 1'b0)) changed = 1'b1;
        if (thin_sweep(w, h, 1'b1)) changed = 1'b1;
      end
      last_passes = passes[bthin_pkg::PASS_W-1:0];
    endfunction

    function void note_command(bthin_pkg::in_item_t c);
      bthin_pkg::out_item_t r;
      r = '0;
      case (c.func)
        bthin_pkg::FUNC_WRITE: store[c.row_index] = c.row_bits & col_mask();
        bthin_pkg::FUNC_THIN:  thin_store();
        bthin_pkg::FUNC_READ:  r.read_bits = store[c.row_index];
        default: ;
      endcase
      r.pass_count = last_passes;
      replies_due.insert(replies_due.size(), r);
    endfunction

    function void check_reply(bthin_pkg::out_item_t got);
      bthin_pkg::out_item_t want;
      if (replies_due.size() == 0) begin
        $error("result with no command waiting: read_bits %h pass_count %0d",
               got.read_bits, got.pass_count);
        fails++;
        return;
      end
      want = replies_due.pop_front();
      if (got.read_bits !== want.read_bits) begin
        $error("read_bits: expected %h, got %h", want.read_bits, got.read_bits);
        fails++;
      end
      if (got.pass_count !== want.pass_count) begin
        $error("pass_count: expected %0d, got %0d", want.pass_count, got.pass_count);
        fails++;
      end
    endfunction

    function int pending();
      return replies_due.size();
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  bthin_pkg::in_item_t  in_data_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  bthin_pkg::out_item_t out_data_o;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [2:0]           paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  thinning_scoreboard sb;
  int gap_pct;
  int stall_pct;
  int sent_count;
  int cycle_count = 0;

  binary_image_thinning uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: check each transfer, then pick the stall for the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_reply(out_data_o);
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  function automatic bthin_pkg::in_item_t make_cmd(logic [bthin_pkg::FUNC_W-1:0] f,
                                                   int row,
                                                   logic [bthin_pkg::ROW_BITS_W-1:0] bits);
    bthin_pkg::in_item_t c;
    c.func      = f;
    c.row_index = row[bthin_pkg::ROW_IDX_W-1:0];
    c.row_bits  = bits;
    return c;
  endfunction

  function automatic logic [bthin_pkg::ROW_BITS_W-1:0] rand_row();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [bthin_pkg::ROW_BITS_W-1:0] row_pattern(int style, int lo,
                                                                   int hi);
    logic [bthin_pkg::ROW_BITS_W-1:0] r;
    r = '0;
    case (style)
      0: r = rand_row();
      1: r = rand_row() & rand_row();
      2: r = rand_row() | rand_row();
      default: begin
        for (int i = lo; i <= hi; i++) r[i] = 1'b1;
        if ($urandom_range(3) == 0) r ^= 64'd1 << $urandom_range(63);
      end
    endcase
    return r;
  endfunction

  // Leaves valid high after the transfer so the next command can follow
  // without a gap; any path that waits must lower it first.
  task automatic send_cmd(bthin_pkg::in_item_t c);
    if (sent_count < 425) begin
      gap_pct   = 36;
      stall_pct = 75;
    end else if (sent_count < 850) begin
      gap_pct   = 75;
      stall_pct = 36;
    end else begin
      gap_pct   = 0;
      stall_pct = 0;
    end
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_command(c);
    sent_count++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_size_reg(logic sel, logic [bthin_pkg::CFG_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= {25'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.set_size(sel, 32'(v));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic maybe_noise();
    if ($urandom_range(99) < 10)
      send_cmd(make_cmd(bthin_pkg::FUNC_W'($urandom_range(3)), int'($urandom_range(63)),
                        rand_row()));
  endtask

  // Image round: load the rows in use, thin, read them back, with random extra commands mixed in.
  task automatic image_round();
    int rows;
    int style;
    int lo;
    int hi;
    rows  = sb.rows_in_use();
    style = $urandom_range(3);
    lo    = $urandom_range(63);
    hi    = $urandom_range(63, lo);
    for (int y = 0; y < rows; y++) begin
      maybe_noise();
      send_cmd(make_cmd(bthin_pkg::FUNC_WRITE, y, row_pattern(style, lo, hi)));
      lo += int'($urandom_range(4)) - 2;
      hi += int'($urandom_range(4)) - 2;
      if (lo < 0) lo = 0;
      if (lo > 63) lo = 63;
      if (hi < lo) hi = lo;
      if (hi > 63) hi = 63;
    end
    if ($urandom_range(3) == 0)
      send_cmd(make_cmd(bthin_pkg::FUNC_WRITE, int'($urandom_range(63)), rand_row()));
    send_cmd(make_cmd(bthin_pkg::FUNC_THIN, int'($urandom_range(63)), rand_row()));
    for (int y = 0; y < rows; y++) begin
      maybe_noise();
      send_cmd(make_cmd(bthin_pkg::FUNC_READ, y, rand_row()));
    end
  endtask

  function automatic logic [bthin_pkg::CFG_W-1:0] pick_width();
    int r;
    r = $urandom_range(99);
    if (r < 60) return bthin_pkg::CFG_W'($urandom_range(16, 3));
    if (r < 70) return bthin_pkg::CFG_W'($urandom_range(2, 1));
    if (r < 80) return 7'd64;
    if (r < 90) return bthin_pkg::CFG_W'($urandom_range(63, 17));
    if (r < 95) return 7'd0;
    return bthin_pkg::CFG_W'($urandom_range(127, 65));
  endfunction

  function automatic logic [bthin_pkg::CFG_W-1:0] pick_height();
    int r;
    r = $urandom_range(99);
    if (r < 65) return bthin_pkg::CFG_W'($urandom_range(10, 1));
    if (r < 80) return bthin_pkg::CFG_W'($urandom_range(24, 11));
    if (r < 88) return bthin_pkg::CFG_W'($urandom_range(127, 64));
    if (r < 95) return bthin_pkg::CFG_W'($urandom_range(63, 25));
    return 7'd0;
  endfunction

  initial begin
    int first_random;
    sb          = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    gap_pct     = 0;
    stall_pct   = 0;
    sent_count  = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Full-size image after reset: thin lines and an unused command.
    send_cmd(make_cmd(bthin_pkg::FUNC_READ, 7, '0));
    send_cmd(make_cmd(FUNC_NONE, 63, '1));
    send_cmd(make_cmd(bthin_pkg::FUNC_WRITE, 0, '1));
    send_cmd(make_cmd(bthin_pkg::FUNC_WRITE, 1, '1));
    send_cmd(make_cmd(bthin_pkg::FUNC_WRITE, 63, {32{2'b10}}));
    send_cmd(make_cmd(bthin_pkg::FUNC_THIN, 0, '0));
    send_cmd(make_cmd(bthin_pkg::FUNC_READ, 0, '0));
    send_cmd(make_cmd(bthin_pkg::FUNC_READ, 1, '0));
    send_cmd(make_cmd(bthin_pkg::FUNC_READ, 63, '0));

    // Smallest useful image; a row below the image keeps its masked write
    // and is left alone by thinning, while wide rows inside are cut back.
    wait_idle();
    write_size_reg(bthin_pkg::REG_IMAGE_WIDTH, 7'd3);
    write_size_reg(bthin_pkg::REG_IMAGE_HEIGHT, 7'd3);
    send_cmd(make_cmd(bthin_pkg::FUNC_WRITE, 0, '1));
    send_cmd(make_cmd(bthin_pkg::FUNC_WRITE, 1, '1));
    send_cmd(make_cmd(bthin_pkg::FUNC_WRITE, 2, '1));
    send_cmd(make_cmd(bthin_pkg::FUNC_WRITE, 40, '1));
    send_cmd(make_cmd(bthin_pkg::FUNC_THIN, 63, '1));
    send_cmd(make_cmd(bthin_pkg::FUNC_READ, 0, '0));
    send_cmd(make_cmd(bthin_pkg::FUNC_READ, 1, '0));
    send_cmd(make_cmd(bthin_pkg::FUNC_READ, 2, '0));
    send_cmd(make_cmd(bthin_pkg::FUNC_READ, 40, '0));

    // Empty image: writes are masked away and thinning runs a single pass.
    wait_idle();
    write_size_reg(bthin_pkg::REG_IMAGE_WIDTH, 7'd0);
    write_size_reg(bthin_pkg::REG_IMAGE_HEIGHT, 7'd0);
    send_cmd(make_cmd(bthin_pkg::FUNC_WRITE, 2, '1));
    send_cmd(make_cmd(bthin_pkg::FUNC_THIN, 0, '0));
    send_cmd(make_cmd(bthin_pkg::FUNC_READ, 2, '0));

    // Oversized width register saturates to the store width.
    wait_idle();
    write_size_reg(bthin_pkg::REG_IMAGE_WIDTH, 7'd127);
    write_size_reg(bthin_pkg::REG_IMAGE_HEIGHT, 7'd1);
    send_cmd(make_cmd(bthin_pkg::FUNC_WRITE, 0, '1));
    send_cmd(make_cmd(bthin_pkg::FUNC_THIN, 0, '0));
    send_cmd(make_cmd(bthin_pkg::FUNC_READ, 0, '0));

    first_random = sent_count;
    while (sent_count < first_random + RANDOM_ITEMS) begin
      wait_idle();
      write_size_reg(bthin_pkg::REG_IMAGE_WIDTH, pick_width());
      write_size_reg(bthin_pkg::REG_IMAGE_HEIGHT, pick_height());
      repeat ($urandom_range(3, 1)) begin
        if (sent_count < first_random + RANDOM_ITEMS) image_round();
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/bthin_pkg.sv
hw/rtl/bthin_lane.sv
hw/rtl/bthin_row.sv
hw/rtl/binary_image_thinning.sv
test/tb_top.sv
